>>> sv/qpp_pkg.sv
// ============================================================================
// qpp_pkg
// Widths, register indexes and pipeline depths shared by the projection
// pipeline and its divider.
// ============================================================================
`default_nettype none

package qpp_pkg;

   localparam int IN_W    = 32;           // every input field
   localparam int FX_W    = 31;           // focal_x and aspect_ratio
   localparam int PROD1_W = 2 * IN_W;     // q * p
   localparam int SUM1_W  = PROD1_W + 2;  // three products
   localparam int S_W     = 52;           // s, a, b, c after the first rounding
   localparam int S_LO_W  = S_W / 2;
   localparam int ROT_W   = 86;           // q * (s, a, b, c) sums
   localparam int P_W     = 42;           // camera frame X, Y, Z
   localparam int P_LO_W  = P_W / 2;
   localparam int FA_W    = 2 * FX_W;     // focal_x * aspect_ratio
   localparam int FA_LO_W = FA_W / 2;
   localparam int NUM_W   = 106;          // divider numerator
   localparam int DEN_W   = P_W + 16;     // divider denominator
   localparam int Q_W     = 32;           // quotient bits
   localparam int CSR_A_W = 8;

   // divider: magnitude, setup, one stage per quotient bit, round and saturate
   localparam int DIV_LAT  = Q_W + 3;
   localparam int FRONT_W  = 8;
   localparam int PIPE_LAT = FRONT_W + DIV_LAT;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_FOCAL_X      = 8'd0,
      CSR_CENTER_X     = 8'd1,
      CSR_CENTER_Y     = 8'd2,
      CSR_ASPECT_RATIO = 8'd3,
      CSR_SKEW_FACTOR  = 8'd4
   } csr_index_type;

   typedef logic signed [NUM_W-1:0] num_type;
   typedef logic [DEN_W-1:0]        den_type;

endpackage

`default_nettype wire

>>> sv/quaternion_pinhole_projection.sv
// ============================================================================
// quaternion_pinhole_projection
// Rotates a point by a quaternion, adds a translation and projects it through
// the pinhole intrinsics to a saturated pixel coordinate.
// ============================================================================
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    quat_w..z, trans_x..z, point_x..z
//   rsp      out        rsp_valid/stall    pixel_u, pixel_v, depth_invalid
//   csr      in         csr_valid/ready    csr_index, csr_data
//
// one request per cycle while the response is not stalled: 8 stages of rotation and
// numerator build, then 35 in the pipelined dividers (one quotient bit a stage)
// a stalled response freezes the whole pipeline, so nothing is lost or repeated
// synchronous reset clears the valid bits and loads the intrinsics defaults
// csr_ready is always high
`default_nettype none

module quaternion_pinhole_projection
   import qpp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [IN_W-1:0]  req_quat_w,
   input  wire logic signed [IN_W-1:0]  req_quat_x,
   input  wire logic signed [IN_W-1:0]  req_quat_y,
   input  wire logic signed [IN_W-1:0]  req_quat_z,
   input  wire logic signed [IN_W-1:0]  req_trans_x,
   input  wire logic signed [IN_W-1:0]  req_trans_y,
   input  wire logic signed [IN_W-1:0]  req_trans_z,
   input  wire logic signed [IN_W-1:0]  req_point_x,
   input  wire logic signed [IN_W-1:0]  req_point_y,
   input  wire logic signed [IN_W-1:0]  req_point_z,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [IN_W-1:0]       rsp_pixel_u,
   output logic signed [IN_W-1:0]       rsp_pixel_v,
   output logic                         rsp_depth_invalid,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_A_W-1:0]      csr_index,
   input  wire logic [IN_W-1:0]         csr_data
);

   localparam int NPROD = 12;

   // ---------------------------------------------------------------- csr
   logic [FX_W-1:0]        fx_ff, asp_ff;
   logic signed [IN_W-1:0] cx_ff, cy_ff, skew_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff   <= FX_W'(65536);
         cx_ff   <= '0;
         cy_ff   <= '0;
         asp_ff  <= FX_W'(65536);
         skew_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOCAL_X:      fx_ff   <= csr_data[FX_W-1:0];
            CSR_CENTER_X:     cx_ff   <= $signed(csr_data);
            CSR_CENTER_Y:     cy_ff   <= $signed(csr_data);
            CSR_ASPECT_RATIO: asp_ff  <= csr_data[FX_W-1:0];
            CSR_SKEW_FACTOR:  skew_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow
   logic adv;
   logic vld_ff [PIPE_LAT];
   logic inv_ff [DIV_LAT+3];
   logic inv_in;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LAT; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < PIPE_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // ---------------------------------------------------------------- stage 1
   // q.v . p and w*p + q.v x p products
   logic signed [PROD1_W-1:0] m1_in [NPROD];
   logic signed [PROD1_W-1:0] m1_ff [NPROD];
   logic signed [IN_W-1:0]    q1_ff [4];
   logic signed [IN_W-1:0]    t1_ff [3];

   always_comb begin
      m1_in[0]  = req_quat_x * req_point_x;
      m1_in[1]  = req_quat_y * req_point_y;
      m1_in[2]  = req_quat_z * req_point_z;
      m1_in[3]  = req_quat_w * req_point_x;
      m1_in[4]  = req_quat_y * req_point_z;
      m1_in[5]  = req_quat_z * req_point_y;
      m1_in[6]  = req_quat_w * req_point_y;
      m1_in[7]  = req_quat_z * req_point_x;
      m1_in[8]  = req_quat_x * req_point_z;
      m1_in[9]  = req_quat_w * req_point_z;
      m1_in[10] = req_quat_x * req_point_y;
      m1_in[11] = req_quat_y * req_point_x;
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [S_W-1:0]  v2_in [4];   // s, a, b, c
   logic signed [S_W-1:0]  v2_ff [4];
   logic signed [IN_W-1:0] q2_ff [4];
   logic signed [IN_W-1:0] t2_ff [3];

   always_comb begin
      logic signed [SUM1_W-1:0] acc [4];
      acc[0] = -(SUM1_W'(m1_ff[0]) + SUM1_W'(m1_ff[1]) + SUM1_W'(m1_ff[2]));
      acc[1] = SUM1_W'(m1_ff[3]) + SUM1_W'(m1_ff[4]) - SUM1_W'(m1_ff[5]);
      acc[2] = SUM1_W'(m1_ff[6]) + SUM1_W'(m1_ff[7]) - SUM1_W'(m1_ff[8]);
      acc[3] = SUM1_W'(m1_ff[9]) + SUM1_W'(m1_ff[10]) - SUM1_W'(m1_ff[11]);
      for (int k = 0; k < 4; k++) begin
         v2_in[k] = S_W'((acc[k] + (SUM1_W'(1) <<< 13)) >>> 14);
      end
   end

   // ---------------------------------------------------------------- stage 3
   // q times (s, a, b, c), each split in two narrower products
   // quaternion order w, x, y, z; vector order s, a, b, c
   localparam int QSEL [NPROD] = '{1, 0, 3, 2,   2, 0, 1, 3,   3, 0, 2, 1};
   localparam int VSEL [NPROD] = '{0, 1, 2, 3,   0, 2, 3, 1,   0, 3, 1, 2};

   logic signed [IN_W+S_LO_W:0]         lo3_in [NPROD];
   logic signed [IN_W+S_LO_W:0]         lo3_ff [NPROD];
   logic signed [IN_W+S_W-S_LO_W-1:0]   hi3_in [NPROD];
   logic signed [IN_W+S_W-S_LO_W-1:0]   hi3_ff [NPROD];
   logic signed [IN_W-1:0]              t3_ff [3];

   always_comb begin
      for (int k = 0; k < NPROD; k++) begin
         lo3_in[k] = q2_ff[QSEL[k]] * $signed({1'b0, v2_ff[VSEL[k]][S_LO_W-1:0]});
         hi3_in[k] = q2_ff[QSEL[k]] * $signed(v2_ff[VSEL[k]][S_W-1:S_LO_W]);
      end
   end

   // ---------------------------------------------------------------- stage 4
   logic signed [ROT_W-1:0] f4_in [NPROD];
   logic signed [ROT_W-1:0] f4_ff [NPROD];
   logic signed [IN_W-1:0]  t4_ff [3];

   always_comb begin
      for (int k = 0; k < NPROD; k++) begin
         f4_in[k] = (ROT_W'(hi3_ff[k]) <<< S_LO_W) + ROT_W'(lo3_ff[k]);
      end
   end

   // ---------------------------------------------------------------- stage 5
   // signs follow -q.v*s + w*a - ... for each axis
   logic signed [P_W-1:0] p5_in [3];
   logic signed [P_W-1:0] p5_ff [3];

   always_comb begin
      logic signed [ROT_W-1:0] acc;
      for (int k = 0; k < 3; k++) begin
         acc = -f4_ff[4*k] + f4_ff[4*k+1] - f4_ff[4*k+2] + f4_ff[4*k+3];
         p5_in[k] = P_W'((acc + (ROT_W'(1) <<< 45)) >>> 46) + P_W'(t4_ff[k]);
      end
   end

   // ---------------------------------------------------------------- stage 6
   localparam int M6L_W = IN_W + P_LO_W + 1;
   localparam int M6H_W = IN_W + P_W - P_LO_W;

   logic signed [M6L_W-1:0] lo6_in [4];  // fx*X, skew*Y, cx*Z, cy*Z
   logic signed [M6L_W-1:0] lo6_ff [4];
   logic signed [M6H_W-1:0] hi6_in [4];
   logic signed [M6H_W-1:0] hi6_ff [4];
   logic [FA_W-1:0]         fa6_in, fa6_ff;
   logic signed [P_W-1:0]   y6_ff, z6_ff;

   always_comb begin
      logic signed [IN_W-1:0] coef [4];
      logic signed [P_W-1:0]  pt   [4];
      coef[0] = $signed({1'b0, fx_ff});
      coef[1] = skew_ff;
      coef[2] = cx_ff;
      coef[3] = cy_ff;
      pt[0]   = p5_ff[0];
      pt[1]   = p5_ff[1];
      pt[2]   = p5_ff[2];
      pt[3]   = p5_ff[2];
      for (int k = 0; k < 4; k++) begin
         lo6_in[k] = coef[k] * $signed({1'b0, pt[k][P_LO_W-1:0]});
         hi6_in[k] = coef[k] * $signed(pt[k][P_W-1:P_LO_W]);
      end
      fa6_in = fx_ff * asp_ff;
      inv_in = p5_ff[2][P_W-1] || (p5_ff[2] == '0);
   end

   // ---------------------------------------------------------------- stage 7
   localparam int M7L_W = FA_LO_W + P_LO_W + 2;
   localparam int M7H_W = FA_LO_W + P_W - P_LO_W + 1;

   num_type                 nu7_in, nu7_ff, cz7_in, cz7_ff;
   logic signed [M7L_W-1:0] ll7_in, ll7_ff, hl7_in, hl7_ff;
   logic signed [M7H_W-1:0] lh7_in, lh7_ff, hh7_in, hh7_ff;
   logic signed [P_W-1:0]   z7_ff;

   always_comb begin
      logic signed [FA_LO_W:0] fa_lo, fa_hi;
      nu7_in = '0;
      for (int k = 0; k < 3; k++) begin
         nu7_in = nu7_in + (NUM_W'(hi6_ff[k]) <<< P_LO_W) + NUM_W'(lo6_ff[k]);
      end
      cz7_in = (NUM_W'(hi6_ff[3]) <<< P_LO_W) + NUM_W'(lo6_ff[3]);
      fa_lo  = $signed({1'b0, fa6_ff[FA_LO_W-1:0]});
      fa_hi  = $signed({1'b0, fa6_ff[FA_W-1:FA_LO_W]});
      ll7_in = fa_lo * $signed({1'b0, y6_ff[P_LO_W-1:0]});
      lh7_in = fa_lo * $signed(y6_ff[P_W-1:P_LO_W]);
      hl7_in = fa_hi * $signed({1'b0, y6_ff[P_LO_W-1:0]});
      hh7_in = fa_hi * $signed(y6_ff[P_W-1:P_LO_W]);
   end

   // ---------------------------------------------------------------- stage 8
   num_type               nu8_ff, nv8_in, nv8_ff;
   logic signed [P_W-1:0] z8_ff;

   assign nv8_in = NUM_W'(ll7_ff) + (NUM_W'(lh7_ff) <<< P_LO_W)
                 + (NUM_W'(hl7_ff) <<< FA_LO_W) + (NUM_W'(hh7_ff) <<< (FA_LO_W + P_LO_W))
                 + (cz7_ff <<< 16);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NPROD; k++) m1_ff[k] <= m1_in[k];
         q1_ff[0] <= req_quat_w;
         q1_ff[1] <= req_quat_x;
         q1_ff[2] <= req_quat_y;
         q1_ff[3] <= req_quat_z;
         t1_ff[0] <= req_trans_x;
         t1_ff[1] <= req_trans_y;
         t1_ff[2] <= req_trans_z;
         for (int k = 0; k < 4; k++) begin
            v2_ff[k] <= v2_in[k];
            q2_ff[k] <= q1_ff[k];
         end
         for (int k = 0; k < NPROD; k++) begin
            lo3_ff[k] <= lo3_in[k];
            hi3_ff[k] <= hi3_in[k];
            f4_ff[k]  <= f4_in[k];
         end
         for (int k = 0; k < 3; k++) begin
            t2_ff[k] <= t1_ff[k];
            t3_ff[k] <= t2_ff[k];
            t4_ff[k] <= t3_ff[k];
            p5_ff[k] <= p5_in[k];
         end
         for (int k = 0; k < 4; k++) begin
            lo6_ff[k] <= lo6_in[k];
            hi6_ff[k] <= hi6_in[k];
         end
         fa6_ff <= fa6_in;
         y6_ff  <= p5_ff[1];
         z6_ff  <= p5_ff[2];
         nu7_ff <= nu7_in;
         cz7_ff <= cz7_in;
         ll7_ff <= ll7_in;
         lh7_ff <= lh7_in;
         hl7_ff <= hl7_in;
         hh7_ff <= hh7_in;
         z7_ff  <= z6_ff;
         nu8_ff <= nu7_ff;
         nv8_ff <= nv8_in;
         z8_ff  <= z7_ff;
         inv_ff[0] <= inv_in;
         for (int k = 1; k < DIV_LAT+3; k++) inv_ff[k] <= inv_ff[k-1];
      end
   end

   // ---------------------------------------------------------------- divide
   logic signed [Q_W-1:0] u_quot, v_quot;

   qpp_divider u_div_u (
      .clock (clock),
      .en    (adv),
      .num   (nu8_ff),
      .den   (DEN_W'($unsigned(z8_ff))),
      .quot  (u_quot)
   );

   qpp_divider u_div_v (
      .clock (clock),
      .en    (adv),
      .num   (nv8_ff),
      .den   ({z8_ff, 16'b0}),
      .quot  (v_quot)
   );

   // behind the camera or at zero depth: flag it and report zero pixels
   assign rsp_depth_invalid = inv_ff[DIV_LAT+2];
   assign rsp_pixel_u       = rsp_depth_invalid ? '0 : u_quot;
   assign rsp_pixel_v       = rsp_depth_invalid ? '0 : v_quot;

endmodule

`default_nettype wire

>>> sv/qpp_divider.sv
// ============================================================================
// qpp_divider
// Pipelined restoring divider: signed numerator over positive denominator,
// rounded to nearest with ties away from zero and saturated to 32 bits.
// ============================================================================
`default_nettype none

module qpp_divider
   import qpp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire num_type               num,
   input  wire den_type               den,
   output logic signed [Q_W-1:0]      quot
);

   localparam int HI_W = NUM_W - Q_W;

   // magnitude stage
   logic                neg_a_ff, neg_a_in;
   logic [NUM_W-1:0]    mag_a_ff, mag_a_in;
   den_type             den_a_ff;

   // one register row per quotient bit, plus the setup row
   logic [DEN_W-1:0]    rem_ff [Q_W+1];
   logic [DEN_W-1:0]    rem_in [Q_W+1];
   logic [Q_W-1:0]      low_ff [Q_W+1];
   logic [Q_W-1:0]      low_in [Q_W+1];
   den_type             den_ff [Q_W+1];
   logic                neg_ff [Q_W+1];
   logic                ovf_ff [Q_W+1];
   logic                ovf_in;

   logic signed [Q_W-1:0] quot_ff, quot_in;

   always_comb begin
      logic [HI_W-1:0] hi;
      logic [DEN_W:0]  t;
      neg_a_in = num[NUM_W-1];
      mag_a_in = neg_a_in ? $unsigned(-num) : $unsigned(num);
      hi       = mag_a_ff[NUM_W-1:Q_W];
      ovf_in   = hi >= HI_W'(den_a_ff);
      rem_in[0] = hi[DEN_W-1:0];
      low_in[0] = mag_a_ff[Q_W-1:0];
      for (int k = 0; k < Q_W; k++) begin
         t = {rem_ff[k], low_ff[k][Q_W-1]};
         if (t >= {1'b0, den_ff[k]}) begin
            rem_in[k+1] = DEN_W'(t - {1'b0, den_ff[k]});
            low_in[k+1] = {low_ff[k][Q_W-2:0], 1'b1};
         end else begin
            rem_in[k+1] = t[DEN_W-1:0];
            low_in[k+1] = {low_ff[k][Q_W-2:0], 1'b0};
         end
      end
   end

   // round on twice the remainder, then clamp to the signed range
   always_comb begin
      logic [Q_W:0] qr, lim, mag;
      logic         rnd;
      rnd = {rem_ff[Q_W], 1'b0} >= {1'b0, den_ff[Q_W]};
      qr  = {1'b0, low_ff[Q_W]} + (Q_W+1)'(rnd);
      lim = neg_ff[Q_W] ? (Q_W+1)'(1) << (Q_W-1) : ((Q_W+1)'(1) << (Q_W-1)) - 1'b1;
      mag = (ovf_ff[Q_W] || (qr > lim)) ? lim : qr;
      quot_in = neg_ff[Q_W] ? $signed(-mag[Q_W-1:0]) : $signed(mag[Q_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff  <= neg_a_in;
         mag_a_ff  <= mag_a_in;
         den_a_ff  <= den;
         rem_ff[0] <= rem_in[0];
         low_ff[0] <= low_in[0];
         den_ff[0] <= den_a_ff;
         neg_ff[0] <= neg_a_ff;
         ovf_ff[0] <= ovf_in;
         for (int k = 0; k < Q_W; k++) begin
            rem_ff[k+1] <= rem_in[k+1];
            low_ff[k+1] <= low_in[k+1];
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

>>> sv/qpp_checker.sv
// ============================================================================
// qpp_checker
// Port-level checks for the projection pipeline, bound to the top level.
// ============================================================================
`default_nettype none

module qpp_checker
   import qpp_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic signed [IN_W-1:0]  rsp_pixel_u,
   input wire logic signed [IN_W-1:0]  rsp_pixel_v,
   input wire logic                    rsp_depth_invalid,
   input wire logic                    csr_ready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_u) && $stable(rsp_pixel_v))
      else $error("stalled response changed");

   a_bad_depth_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_depth_invalid |-> rsp_pixel_u == '0 && rsp_pixel_v == '0)
      else $error("invalid depth with nonzero pixels");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall && csr_ready)
      else $error("request taken while the response is stalled");

endmodule

bind quaternion_pinhole_projection qpp_checker u_qpp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pixel_u       (rsp_pixel_u),
   .rsp_pixel_v       (rsp_pixel_v),
   .rsp_depth_invalid (rsp_depth_invalid),
   .csr_ready         (csr_ready)
);

`default_nettype wire

>>> tb/quaternion_pinhole_projection_tb.sv
// ============================================================================
// quaternion_pinhole_projection_tb
// Drives rotate/translate/project requests through the pipeline with random
// gaps and response stalls, predicts every pixel pair in exact wide integer
// arithmetic and checks the responses in order across several intrinsics.
// ============================================================================
`timescale 1ns / 1ps

module quaternion_pinhole_projection_tb;
   import qpp_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [IN_W-1:0] qw, qx, qy, qz;
      logic signed [IN_W-1:0] tx, ty, tz;
      logic signed [IN_W-1:0] px, py, pz;
   } proj_req_type;

   typedef struct {
      logic signed [IN_W-1:0] u, v;
      logic                   bad_depth;
   } pixel_type;

   localparam logic [CSR_A_W-1:0] CSR_UNUSED_INDEX = 8'd5;
   localparam logic [CSR_A_W-1:0] CSR_TOP_INDEX    = 8'd255;

   class pixel_scoreboard;
      pixel_type        pixel_queue[$];
      int               mismatches = 0;
      logic [FX_W-1:0]  focal_x = 31'd65536;
      logic [FX_W-1:0]  aspect  = 31'd65536;
      logic signed [31:0] center_x = 0, center_y = 0, skew = 0;

      function void set_csr(logic [CSR_A_W-1:0] idx, logic [IN_W-1:0] data);
         case (idx)
            CSR_FOCAL_X:      focal_x  = data[FX_W-1:0];
            CSR_CENTER_X:     center_x = data;
            CSR_CENTER_Y:     center_y = data;
            CSR_ASPECT_RATIO: aspect   = data[FX_W-1:0];
            CSR_SKEW_FACTOR:  skew     = data;
            default: ;
         endcase
      endfunction

      function wide_type round_shift(wide_type v, int n);
         wide_type t;
         t = v + (wide_type'(1) <<< (n - 1));
         t = t >>> n;
         return wide_type'($signed(t[63:0]));
      endfunction

      // round to nearest, ties away from zero, then clamp to 32 bits
      function logic signed [31:0] div_sat(wide_type num, wide_type den);
         logic [127:0] mag, d, q, r, lim;
         logic neg;
         neg = num < 0;
         mag = neg ? -num : num;
         d = den;
         q = mag / d;
         r = mag - q * d;
         if (r >= d - r) q = q + 1;
         lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
         if (q > lim) q = lim;
         return neg ? -q[31:0] : q[31:0];
      endfunction

      function pixel_type project(proj_req_type r);
         wide_type qw, qx, qy, qz, px, py, pz, s, a, b, c, cx, cy, sk, fx, fa;
         wide_type cam_x, cam_y, cam_z, num;
         pixel_type res;
         qw = r.qw; qx = r.qx; qy = r.qy; qz = r.qz;
         px = r.px; py = r.py; pz = r.pz;
         s = round_shift(-(qx * px) - qy * py - qz * pz, 14);
         a = round_shift(qw * px + qy * pz - qz * py, 14);
         b = round_shift(qw * py + qz * px - qx * pz, 14);
         c = round_shift(qw * pz + qx * py - qy * px, 14);
         cam_x = round_shift(-(qx * s) + qw * a - qz * b + qy * c, 46) + wide_type'(r.tx);
         cam_y = round_shift(-(qy * s) + qw * b - qx * c + qz * a, 46) + wide_type'(r.ty);
         cam_z = round_shift(-(qz * s) + qw * c - qy * a + qx * b, 46) + wide_type'(r.tz);
         res.u = 0;
         res.v = 0;
         res.bad_depth = !(cam_z > 0);
         if (cam_z > 0) begin
            fx = {97'b0, focal_x};
            fa = fx * {97'b0, aspect};
            cx = center_x; cy = center_y; sk = skew;
            num = fx * cam_x + sk * cam_y + cx * cam_z;
            res.u = div_sat(num, cam_z);
            num = fa * cam_y + ((cy * cam_z) <<< 16);
            res.v = div_sat(num, cam_z <<< 16);
         end
         return res;
      endfunction

      function void note_request(proj_req_type r);
         pixel_queue.push_back(project(r));
      endfunction

      function void check_response(pixel_type got);
         pixel_type want;
         if (pixel_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response u=%0d v=%0d bad=%0b", got.u, got.v, got.bad_depth);
            return;
         end
         want = pixel_queue.pop_front();
         if (got.u !== want.u || got.v !== want.v || got.bad_depth !== want.bad_depth) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected u=%0d v=%0d bad=%0b, got u=%0d v=%0d bad=%0b",
                        want.u, want.v, want.bad_depth, got.u, got.v, got.bad_depth);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0;
   logic signed [IN_W-1:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic signed [IN_W-1:0] req_trans_x = 0, req_trans_y = 0, req_trans_z = 0;
   logic signed [IN_W-1:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic [CSR_A_W-1:0] csr_index = 0;
   logic [IN_W-1:0]    csr_data = 0;
   logic req_stall, rsp_valid, rsp_depth_invalid, csr_ready;
   logic signed [IN_W-1:0] rsp_pixel_u, rsp_pixel_v;
   bit quiet = 0;

   pixel_scoreboard sb = new();

   quaternion_pinhole_projection u_top (.*);

   initial forever #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock)
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 22);

   always @(posedge clock) begin
      pixel_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.u = rsp_pixel_u;
         got.v = rsp_pixel_v;
         got.bad_depth = rsp_depth_invalid;
         sb.check_response(got);
      end
   end

   task automatic send(proj_req_type r);
      req_valid <= 1;
      req_quat_w <= r.qw; req_quat_x <= r.qx; req_quat_y <= r.qy; req_quat_z <= r.qz;
      req_trans_x <= r.tx; req_trans_y <= r.ty; req_trans_z <= r.tz;
      req_point_x <= r.px; req_point_y <= r.py; req_point_z <= r.pz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      if (!quiet && $urandom_range(99) < 22) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [CSR_A_W-1:0] idx, logic [IN_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_csr(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pixel_queue.size() > 0) @(posedge clock);
      repeat (PIPE_LAT + 8) @(posedge clock);
   endtask

   task automatic set_intrinsics(logic [31:0] fx, logic [31:0] cx, logic [31:0] cy,
                                 logic [31:0] asp, logic [31:0] sk);
      csr_write(CSR_FOCAL_X, fx);
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      csr_write(CSR_ASPECT_RATIO, asp);
      csr_write(CSR_SKEW_FACTOR, sk);
   endtask

   function automatic proj_req_type make_req(logic [31:0] qw, logic [31:0] qx,
         logic [31:0] qy, logic [31:0] qz, logic [31:0] tx, logic [31:0] ty,
         logic [31:0] tz, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      proj_req_type r;
      r.qw = qw; r.qx = qx; r.qy = qy; r.qz = qz;
      r.tx = tx; r.ty = ty; r.tz = tz;
      r.px = px; r.py = py; r.pz = pz;
      return r;
   endfunction

   function automatic logic [31:0] sym_range(int unsigned span);
      return $urandom_range(2 * span) - span;
   endfunction

   function automatic proj_req_type random_req();
      proj_req_type r;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         // near-unit rotation with a small random translation and point
         r = make_req(32'h4000_0000 - $urandom_range(1 << 21), sym_range(1 << 23),
                      sym_range(1 << 23), sym_range(1 << 23),
                      sym_range(50 << 16), sym_range(50 << 16), $urandom_range(1 << 22),
                      sym_range(100 << 16), sym_range(100 << 16), sym_range(1 << 23));
         if ($urandom_range(3) == 0) r.qw = -r.qw;
      end else if (pick < 85) begin
         r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      end else begin
         // edge values and depth near zero
         r = make_req(32'h4000_0000, 0, 0, 0, sym_range(4), sym_range(4), sym_range(3),
                      sym_range(4), sym_range(4), sym_range(3));
         if ($urandom_range(1)) r.qw = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         if ($urandom_range(1)) r.px = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         if ($urandom_range(1)) r.tx = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      end
      return r;
   endfunction

   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset intrinsics
      send(make_req(ONE_Q30, 0, 0, 0, 0, 0, 0, ONE_Q16, ONE_Q16, ONE_Q16));
      send(make_req(ONE_Q30, 0, 0, 0, 0, 0, 0, 5 << 16, -(3 << 16), 2 << 16));
      send(make_req(ONE_Q30, 0, 0, 0, 0, 0, 0, ONE_Q16, ONE_Q16, 0));          // depth zero
      send(make_req(ONE_Q30, 0, 0, 0, 0, 0, -5, ONE_Q16, ONE_Q16, 0));         // behind camera
      send(make_req(ONE_Q30, 0, 0, 0, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 0));
      send(make_req(759250125, 759250125, 0, 0, 0, 0, 0, ONE_Q16, ONE_Q16, ONE_Q16));
      send(make_req(0, 0, ONE_Q30, 0, 0, 0, 0, 0, 0, -(7 << 16)));             // half turn
      send(make_req(-ONE_Q30, -ONE_Q30, -ONE_Q30, -ONE_Q30, 0, 0, ONE_Q16, 1, 2, 3));
      send(make_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send(make_req(0, 0, 0, 0, 0, 0, 0, $urandom, $urandom, $urandom));
      send(make_req(0, 0, 0, 0, 1, -1, 2, 0, 0, 0));                           // zero rotation, translation only
      send(make_req(ONE_Q30, 0, 0, 0, 32'h7fff_ffff, 0, 1, 0, 0, 0));          // saturate
      send(make_req(ONE_Q30, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 0));
      drain();

      set_intrinsics(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000);
      csr_write(CSR_UNUSED_INDEX, 32'hdead_beef);
      csr_write(CSR_TOP_INDEX, 32'h1234_5678);
      send(make_req(ONE_Q30, 0, 0, 0, 0, 0, 0, ONE_Q16, ONE_Q16, ONE_Q16));
      send(make_req(ONE_Q30, 0, 0, 0, 0, 0, 1, ONE_Q16, -ONE_Q16, 0));
      send(make_req(ONE_Q30, 0, 0, 0, 0, 0, 0, -ONE_Q16, ONE_Q16, 32'h7fff_ffff));

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: set_intrinsics(0, 0, 0, 0, 0);
            1: set_intrinsics(500 << 16, 320 << 16, 240 << 16, ONE_Q16, 0);
            2: set_intrinsics(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                              32'h7fff_ffff);
            default: set_intrinsics($urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         quiet = (phase == 3);
         repeat (155) send(random_req());
      end
      quiet = 0;
      drain();
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
sv/qpp_pkg.sv
sv/qpp_divider.sv
sv/quaternion_pinhole_projection.sv
sv/qpp_checker.sv
tb/quaternion_pinhole_projection_tb.sv
